// ===== sv/button_press_classifier_core_macros.svh =====
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold in the same cycle as the trigger.
`define BPC_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("button press classifier assertion failed");

// The condition must hold in the cycle after the trigger.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("button press classifier assertion failed");

`else

`define BPC_ASSERT_NOW(lbl, clk, rst_n, trig, cond)
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button press classifier package
// Phase, report kind and register codes, reset values and the mark table.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEVEL_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSED   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_DOUBLE    = 5'd3;
    localparam logic [PHASE_W-1:0] PH_LONG      = 5'd4;
    localparam logic [PHASE_W-1:0] PH_LAST_MARK = 5'd16;

    localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
    localparam logic [2:0] REG_DOUBLE_CLICK = 3'd3;
    localparam logic [2:0] REG_TICKS_PER_S  = 3'd4;

    localparam logic        RST_ENABLE       = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd5;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd100;
    localparam logic [15:0] RST_DOUBLE_CLICK = 16'd40;
    localparam logic [10:0] RST_TICKS_PER_S  = 11'd100;

    function automatic logic [4:0] mark_secs(input logic [3:0] idx);
        logic [4:0] secs;
        case (idx)
            4'd0:    secs = 5'd2;
            4'd1:    secs = 5'd4;
            4'd2:    secs = 5'd5;
            4'd3:    secs = 5'd8;
            4'd4:    secs = 5'd10;
            4'd5:    secs = 5'd13;
            4'd6:    secs = 5'd15;
            4'd7:    secs = 5'd18;
            4'd8:    secs = 5'd20;
            4'd9:    secs = 5'd23;
            4'd10:   secs = 5'd25;
            4'd11:   secs = 5'd30;
            default: secs = 5'd0;
        endcase
        return secs;
    endfunction

endpackage

// ===== sv/bpc_tick_if.sv =====
// ----------------------------------------------------------------------------
// Button press classifier tick channel
// Carries one sampled button level per transaction.
// ----------------------------------------------------------------------------
interface bpc_tick_if;
    logic valid;
    logic ready;
    logic button_down;

    modport source (output valid, output button_down, input ready);
    modport sink   (input valid, input button_down, output ready);
endinterface

// ===== sv/bpc_rpt_if.sv =====
// ----------------------------------------------------------------------------
// Button press classifier report channel
// Carries the per-tick classification result, one per transaction.
// ----------------------------------------------------------------------------
interface bpc_rpt_if;
    logic                            valid;
    logic                            ready;
    logic                            report_valid;
    logic [bpc_pkg::KIND_W-1:0]      report_kind;
    logic [bpc_pkg::LEVEL_W-1:0]     report_level;
    logic                            stage_pulse;
    logic                            key_held;
    logic [bpc_pkg::PHASE_W-1:0]     hold_phase;

    modport source (output valid, output report_valid, output report_kind,
                    output report_level, output stage_pulse, output key_held,
                    output hold_phase, input ready);
    modport sink   (input valid, input report_valid, input report_kind,
                    input report_level, input stage_pulse, input key_held,
                    input hold_phase, output ready);
endinterface

// ===== sv/button_press_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Button press classifier core
// Debounces a button, tracks hold stages and reports short, double and long
// presses, one result transaction per tick transaction.
// ----------------------------------------------------------------------------
//  Channel    Direction  Payload
//  i_tick     in         button_down
//  o_rpt      out        report_valid, report_kind, report_level, stage_pulse,
//                        key_held, hold_phase
//  APB        in/out     five registers at byte addresses 0, 4, 8, 12, 16
//
//  One tick transaction is accepted per cycle unless both stages hold; each
//  passes the input register and then the result register, which presents it.
//  The classification state updates in a single pass between the two.
//  A stall on o_rpt holds both stages; i_tick.ready drops only when both hold.
//  Synchronous reset clears the state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "button_press_classifier_core_macros.svh"

module button_press_classifier_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bpc_tick_if.sink            i_tick,
    bpc_rpt_if.source           o_rpt,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef struct packed {
        logic                            report_valid;
        logic [bpc_pkg::KIND_W-1:0]      report_kind;
        logic [bpc_pkg::LEVEL_W-1:0]     report_level;
        logic                            stage_pulse;
        logic                            key_held;
        logic [bpc_pkg::PHASE_W-1:0]     hold_phase;
    } t_result;

    logic                         r_enable;
    logic [15:0]                  r_debounce;
    logic [15:0]                  r_long;
    logic [15:0]                  r_dclick;
    logic [10:0]                  r_tps;

    logic [bpc_pkg::PHASE_W-1:0]  r_phase;
    logic [bpc_pkg::PHASE_W-1:0]  n_phase;
    logic [CW-1:0]                r_hold;
    logic [CW-1:0]                n_hold;
    logic                         r_press;
    logic                         n_press;
    logic                         r_dpend;
    logic                         n_dpend;
    logic [CW-1:0]                r_dcnt;
    logic [CW-1:0]                n_dcnt;

    logic                         r_s1_valid;
    logic                         r_s1_down;
    logic                         r_out_valid;
    t_result                      r_out;
    t_result                      n_out;

    logic                         s2_rdy;
    logic                         s1_fire;
    logic                         in_fire;
    logic                         cfg_wr;
    logic [15:0]                  mark_thr;
    logic                         released;
    logic                         report;
    logic [bpc_pkg::KIND_W-1:0]   kind;
    logic [bpc_pkg::LEVEL_W-1:0]  level;
    logic                         pulse;

    assign s2_rdy       = !r_out_valid || o_rpt.ready;
    assign s1_fire      = r_s1_valid && s2_rdy;
    assign i_tick.ready = !r_s1_valid || s2_rdy;
    assign in_fire      = i_tick.valid && i_tick.ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            bpc_pkg::REG_ENABLE:       prdata = {31'd0, r_enable};
            bpc_pkg::REG_DEBOUNCE:     prdata = {16'd0, r_debounce};
            bpc_pkg::REG_LONG_PRESS:   prdata = {16'd0, r_long};
            bpc_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, r_dclick};
            bpc_pkg::REG_TICKS_PER_S:  prdata = {21'd0, r_tps};
            default:                   prdata = 32'd0;
        endcase
    end

    assign mark_thr = 16'(bpc_pkg::mark_secs(4'(r_phase - bpc_pkg::PH_LONG))) * 16'(r_tps);

    always_comb begin
        n_phase  = r_phase;
        n_hold   = r_hold;
        n_press  = r_press;
        n_dpend  = r_dpend;
        n_dcnt   = r_dcnt;
        released = 1'b0;
        report   = 1'b0;
        kind     = bpc_pkg::KIND_SHORT;
        level    = '0;
        pulse    = 1'b0;

        if (r_enable) begin
            if (!r_s1_down) begin
                if (r_phase >= bpc_pkg::PH_PRESSED) begin
                    released = 1'b1;
                    if (r_dpend) begin
                        n_phase = bpc_pkg::PH_IDLE;
                    end
                end else begin
                    n_hold = '0;
                end
            end else begin
                if (r_phase == bpc_pkg::PH_IDLE) begin
                    n_hold  = '0;
                    n_phase = bpc_pkg::PH_DEBOUNCE;
                end else if (r_hold != CNT_MAX) begin
                    n_hold = r_hold + CW'(1);
                end
                if (n_phase == bpc_pkg::PH_DEBOUNCE) begin
                    if (CMP_W'(n_hold) == CMP_W'(r_debounce)) begin
                        n_phase = bpc_pkg::PH_PRESSED;
                        n_press = 1'b1;
                        if (r_dpend && (CMP_W'(r_dcnt) <= CMP_W'(r_dclick))) begin
                            n_phase = bpc_pkg::PH_DOUBLE;
                            n_dpend = 1'b0;
                            n_dcnt  = '0;
                        end
                    end
                end else if (n_phase == bpc_pkg::PH_PRESSED) begin
                    if (CMP_W'(n_hold) == CMP_W'(r_long)) begin
                        n_dpend = 1'b0;
                        n_dcnt  = '0;
                        n_phase = bpc_pkg::PH_LONG;
                    end
                end else if (n_phase >= bpc_pkg::PH_LONG && n_phase < bpc_pkg::PH_LAST_MARK) begin
                    if (CMP_W'(n_hold) == CMP_W'(mark_thr)) begin
                        n_phase = n_phase + 5'd1;
                        pulse   = 1'b1;
                    end
                end
            end

            if (r_press && released) begin
                n_press = 1'b0;
                if (n_phase == bpc_pkg::PH_DOUBLE) begin
                    report = 1'b1;
                    kind   = bpc_pkg::KIND_DOUBLE;
                end else if (CMP_W'(n_hold) >= CMP_W'(r_long)) begin
                    report = 1'b1;
                    kind   = bpc_pkg::KIND_LONG;
                    level  = (n_phase >= bpc_pkg::PH_LONG) ? 4'(n_phase - 5'd3) : 4'd1;
                end else if (!n_dpend) begin
                    n_dpend = 1'b1;
                    n_dcnt  = '0;
                end
                n_hold = '0;
            end
        end

        if (n_dpend) begin
            if (CMP_W'(n_dcnt) >= CMP_W'(r_dclick)) begin
                n_dpend = 1'b0;
                n_dcnt  = '0;
                report  = 1'b1;
                kind    = bpc_pkg::KIND_SHORT;
                level   = '0;
            end else if (n_dcnt != CNT_MAX) begin
                n_dcnt = n_dcnt + CW'(1);
            end
        end

        if (report) begin
            n_phase = bpc_pkg::PH_IDLE;
        end

        n_out.report_valid = report;
        n_out.report_kind  = kind;
        n_out.report_level = level;
        n_out.stage_pulse  = pulse;
        n_out.key_held     = n_press;
        n_out.hold_phase   = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= bpc_pkg::PH_IDLE;
            r_hold      <= '0;
            r_press     <= 1'b0;
            r_dpend     <= 1'b0;
            r_dcnt      <= '0;
            r_enable    <= bpc_pkg::RST_ENABLE;
            r_debounce  <= bpc_pkg::RST_DEBOUNCE;
            r_long      <= bpc_pkg::RST_LONG_PRESS;
            r_dclick    <= bpc_pkg::RST_DOUBLE_CLICK;
            r_tps       <= bpc_pkg::RST_TICKS_PER_S;
        end else begin
            if (i_tick.ready) begin
                r_s1_valid <= i_tick.valid;
            end
            if (s2_rdy) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_phase <= n_phase;
                r_hold  <= n_hold;
                r_press <= n_press;
                r_dpend <= n_dpend;
                r_dcnt  <= n_dcnt;
            end
            if (cfg_wr) begin
                case (paddr[4:2])
                    bpc_pkg::REG_ENABLE:       r_enable   <= pwdata[0];
                    bpc_pkg::REG_DEBOUNCE:     r_debounce <= pwdata[15:0];
                    bpc_pkg::REG_LONG_PRESS:   r_long     <= pwdata[15:0];
                    bpc_pkg::REG_DOUBLE_CLICK: r_dclick   <= pwdata[15:0];
                    bpc_pkg::REG_TICKS_PER_S:  r_tps      <= pwdata[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_down <= i_tick.button_down;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rpt.valid        = r_out_valid;
    assign o_rpt.report_valid = r_out.report_valid;
    assign o_rpt.report_kind  = r_out.report_kind;
    assign o_rpt.report_level = r_out.report_level;
    assign o_rpt.stage_pulse  = r_out.stage_pulse;
    assign o_rpt.key_held     = r_out.key_held;
    assign o_rpt.hold_phase   = r_out.hold_phase;

    `BPC_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s1_fire, r_out_valid)
    `BPC_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !s1_fire, $stable(r_phase) && $stable(r_hold) && $stable(r_dcnt) && $stable(r_dpend))
    `BPC_ASSERT_NOW(a_report_idle, i_clk, i_rst_n, r_out_valid && r_out.report_valid, r_out.hold_phase == bpc_pkg::PH_IDLE)
    `BPC_ASSERT_NOW(a_pulse_mark, i_clk, i_rst_n, r_out_valid && r_out.stage_pulse && !r_out.report_valid, r_out.hold_phase > bpc_pkg::PH_LONG && r_out.hold_phase <= bpc_pkg::PH_LAST_MARK)

endmodule

// ===== dv/button_press_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// Button press classifier core testbench
// Drives button tick transactions and register writes into the core, predicts
// every report transaction with a cycle-free model of the classifier, and
// compares each field of every report in order of arrival.
// ----------------------------------------------------------------------------
module button_press_classifier_core_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [59:0] SECOND_MARKS = {5'd30, 5'd25, 5'd23, 5'd20, 5'd18, 5'd15,
                                            5'd13, 5'd10, 5'd8, 5'd5, 5'd4, 5'd2};

    typedef struct packed {
        logic                        report_valid;
        logic [bpc_pkg::KIND_W-1:0]  report_kind;
        logic [bpc_pkg::LEVEL_W-1:0] report_level;
        logic                        stage_pulse;
        logic                        key_held;
        logic [bpc_pkg::PHASE_W-1:0] hold_phase;
    } t_tick_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bpc_tick_if tick_if ();
    bpc_rpt_if  rpt_if ();

    button_press_classifier_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .o_rpt   (rpt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic        cfg_enable = bpc_pkg::RST_ENABLE;
    logic [15:0] cfg_debounce = bpc_pkg::RST_DEBOUNCE;
    logic [15:0] cfg_long_press = bpc_pkg::RST_LONG_PRESS;
    logic [15:0] cfg_double_click = bpc_pkg::RST_DOUBLE_CLICK;
    logic [10:0] cfg_ticks_per_s = bpc_pkg::RST_TICKS_PER_S;

    logic [bpc_pkg::PHASE_W-1:0] st_phase = bpc_pkg::PH_IDLE;
    logic [15:0]                 st_hold = '0;
    logic                        st_press_active = 1'b0;
    logic                        st_double_pending = 1'b0;
    logic [15:0]                 st_double_count = '0;

    t_tick_report queued_reports[$];
    int unsigned  errors = 0;
    int unsigned  sent_ticks = 0;
    int unsigned  cycle_count = 0;
    int unsigned  tick_idle_pct = 0;
    int unsigned  rpt_stall_pct = 0;

    always #5 clk = ~clk;

    function automatic t_tick_report classify_tick(input logic down);
        t_tick_report r;
        logic         released;
        logic         reported;
        int unsigned  mark_idx;
        int unsigned  mark_ticks;
        r = '0;
        released = 1'b0;
        reported = 1'b0;
        if (cfg_enable) begin
            if (!down) begin
                if (st_phase >= bpc_pkg::PH_PRESSED) begin
                    released = 1'b1;
                    if (st_double_pending) begin
                        st_phase = bpc_pkg::PH_IDLE;
                    end
                end else begin
                    st_hold = '0;
                end
            end else begin
                if (st_phase == bpc_pkg::PH_IDLE) begin
                    st_hold = '0;
                    st_phase = bpc_pkg::PH_DEBOUNCE;
                end else if (st_hold != COUNT_MAX) begin
                    st_hold++;
                end
                if (st_phase == bpc_pkg::PH_DEBOUNCE) begin
                    if (st_hold == cfg_debounce) begin
                        st_phase = bpc_pkg::PH_PRESSED;
                        st_press_active = 1'b1;
                        if (st_double_pending && st_double_count <= cfg_double_click) begin
                            st_phase = bpc_pkg::PH_DOUBLE;
                            st_double_pending = 1'b0;
                            st_double_count = '0;
                        end
                    end
                end else if (st_phase == bpc_pkg::PH_PRESSED) begin
                    if (st_hold == cfg_long_press) begin
                        st_double_pending = 1'b0;
                        st_double_count = '0;
                        st_phase = bpc_pkg::PH_LONG;
                    end
                end else if (st_phase >= bpc_pkg::PH_LONG &&
                             st_phase < bpc_pkg::PH_LAST_MARK) begin
                    mark_idx = int'(st_phase) - int'(bpc_pkg::PH_LONG);
                    mark_ticks = int'(SECOND_MARKS[mark_idx*5 +: 5]) * int'(cfg_ticks_per_s);
                    if (int'(st_hold) == mark_ticks) begin
                        st_phase++;
                        r.stage_pulse = 1'b1;
                    end
                end
            end
            if (st_press_active && released) begin
                st_press_active = 1'b0;
                if (st_phase == bpc_pkg::PH_DOUBLE) begin
                    reported = 1'b1;
                    r.report_kind = bpc_pkg::KIND_DOUBLE;
                end else if (st_hold >= cfg_long_press) begin
                    reported = 1'b1;
                    r.report_kind = bpc_pkg::KIND_LONG;
                    r.report_level = (st_phase >= bpc_pkg::PH_LONG) ?
                        bpc_pkg::LEVEL_W'(st_phase - bpc_pkg::PH_LONG + 5'd1) :
                        bpc_pkg::LEVEL_W'(1);
                end else if (!st_double_pending) begin
                    st_double_pending = 1'b1;
                    st_double_count = '0;
                end
                st_hold = '0;
            end
        end
        if (st_double_pending) begin
            if (st_double_count >= cfg_double_click) begin
                st_double_pending = 1'b0;
                st_double_count = '0;
                reported = 1'b1;
                r.report_kind = bpc_pkg::KIND_SHORT;
                r.report_level = '0;
            end else if (st_double_count != COUNT_MAX) begin
                st_double_count++;
            end
        end
        if (reported) begin
            st_phase = bpc_pkg::PH_IDLE;
        end
        r.report_valid = reported;
        r.key_held = st_press_active;
        r.hold_phase = st_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : report_check
        t_tick_report want;
        if (rst_n) begin
            if (tick_if.valid && tick_if.ready) begin
                queued_reports.push_back(classify_tick(tick_if.button_down));
            end
            if (rpt_if.valid && rpt_if.ready) begin
                if (queued_reports.size() == 0) begin
                    errors++;
                    $display("%0t: report transaction mismatch, expected none, actual phase %0d",
                             $time, rpt_if.hold_phase);
                end else begin
                    want = queued_reports.pop_front();
                    check_field("report_valid", 16'(want.report_valid),
                                16'(rpt_if.report_valid));
                    check_field("report_kind", 16'(want.report_kind),
                                16'(rpt_if.report_kind));
                    check_field("report_level", 16'(want.report_level),
                                16'(rpt_if.report_level));
                    check_field("stage_pulse", 16'(want.stage_pulse),
                                16'(rpt_if.stage_pulse));
                    check_field("key_held", 16'(want.key_held), 16'(rpt_if.key_held));
                    check_field("hold_phase", 16'(want.hold_phase),
                                16'(rpt_if.hold_phase));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        rpt_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            rpt_if.ready <= ($urandom_range(99) >= rpt_stall_pct);
        end
    end

    task automatic send_tick(input logic down);
        @(negedge clk);
        while ($urandom_range(99) < tick_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(negedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.button_down <= down;
        do @(posedge clk); while (!tick_if.ready);
        sent_ticks++;
    endtask

    task automatic hold_level(input logic down, input int unsigned n);
        repeat (n) send_tick(down);
    endtask

    task automatic drain();
        @(negedge clk);
        tick_if.valid <= 1'b0;
        while (queued_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            bpc_pkg::REG_ENABLE:       cfg_enable = value[0];
            bpc_pkg::REG_DEBOUNCE:     cfg_debounce = value[15:0];
            bpc_pkg::REG_LONG_PRESS:   cfg_long_press = value[15:0];
            bpc_pkg::REG_DOUBLE_CLICK: cfg_double_click = value[15:0];
            bpc_pkg::REG_TICKS_PER_S:  cfg_ticks_per_s = value[10:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic en, input logic [15:0] deb, input logic [15:0] lp,
                             input logic [15:0] dc, input logic [10:0] tps);
        drain();
        write_reg(bpc_pkg::REG_ENABLE, 32'(en));
        write_reg(bpc_pkg::REG_DEBOUNCE, 32'(deb));
        write_reg(bpc_pkg::REG_LONG_PRESS, 32'(lp));
        write_reg(bpc_pkg::REG_DOUBLE_CLICK, 32'(dc));
        write_reg(bpc_pkg::REG_TICKS_PER_S, 32'(tps));
    endtask

    task automatic test_registers();
        logic [31:0] want;
        logic [2:0]  idx;
        for (int round = 0; round < 3; round++) begin
            if (round == 1) begin
                configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
            end else if (round == 2) begin
                configure(1'b0, 16'h0000, 16'h0000, 16'h0000, 11'h000);
            end
            for (int r = 0; r < 5; r++) begin
                idx = r[2:0];
                case (idx)
                    bpc_pkg::REG_ENABLE:       want = 32'(cfg_enable);
                    bpc_pkg::REG_DEBOUNCE:     want = 32'(cfg_debounce);
                    bpc_pkg::REG_LONG_PRESS:   want = 32'(cfg_long_press);
                    bpc_pkg::REG_DOUBLE_CLICK: want = 32'(cfg_double_click);
                    default:                   want = 32'(cfg_ticks_per_s);
                endcase
                @(negedge clk);
                psel <= 1'b1;
                penable <= 1'b0;
                pwrite <= 1'b0;
                paddr <= {idx, 2'b00};
                @(negedge clk);
                penable <= 1'b1;
                do @(posedge clk); while (!pready);
                if (prdata !== want) begin
                    errors++;
                    $display("%0t: register %0d mismatch, expected %0h, actual %0h",
                             $time, idx, want, prdata);
                end
                @(negedge clk);
                psel <= 1'b0;
                penable <= 1'b0;
            end
        end
    endtask

    task automatic test_basic_presses();
        configure(1'b1, 16'd2, 16'd6, 16'd4, 11'd1);
        hold_level(1'b1, 2);
        hold_level(1'b0, 1);
        hold_level(1'b1, 3);
        hold_level(1'b0, 6);
        hold_level(1'b1, 3);
        hold_level(1'b0, 2);
        hold_level(1'b1, 3);
        hold_level(1'b0, 2);
        hold_level(1'b1, 8);
        hold_level(1'b0, 2);
        configure(1'b1, 16'd2, 16'd6, 16'd1, 11'd1);
        hold_level(1'b1, 3);
        hold_level(1'b0, 4);
    endtask

    // Long enough at two ticks per second to cross every mark up to 30 s.
    task automatic test_hold_marks();
        configure(1'b1, 16'd1, 16'd2, 16'd3, 11'd2);
        hold_level(1'b0, 6);
        hold_level(1'b1, 65);
        hold_level(1'b0, 2);
    endtask

    task automatic test_enable_gating();
        configure(1'b1, 16'd1, 16'd8, 16'd6, 11'd2);
        hold_level(1'b1, 3);
        hold_level(1'b0, 1);
        configure(1'b0, 16'd1, 16'd8, 16'd6, 11'd2);
        hold_level(1'b1, 10);
        configure(1'b1, 16'd1, 16'd8, 16'd6, 11'd2);
        hold_level(1'b0, 3);
    endtask

    task automatic test_zero_and_max_settings();
        configure(1'b1, 16'd0, 16'd0, 16'd0, 11'd0);
        hold_level(1'b1, 3);
        hold_level(1'b0, 3);
        hold_level(1'b1, 2);
        hold_level(1'b0, 2);
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
        hold_level(1'b1, 4);
        hold_level(1'b0, 2);
    endtask

    task automatic test_random_sessions(input int unsigned n_ticks);
        int unsigned stop_at;
        int unsigned press_len;
        int unsigned gap_len;
        stop_at = sent_ticks + n_ticks;
        while (sent_ticks < stop_at) begin
            if ($urandom_range(7) == 0) begin
                configure(1'b1,
                          $urandom_range(1) ? 16'hFFFF : 16'h0000,
                          $urandom_range(1) ? 16'hFFFF : 16'h0001,
                          $urandom_range(1) ? 16'hFFFF : 16'h0000,
                          $urandom_range(1) ? 11'h7FF : 11'h000);
            end else begin
                configure($urandom_range(9) != 0, 16'($urandom_range(4)),
                          16'($urandom_range(1, 20)), 16'($urandom_range(12)),
                          11'($urandom_range(6)));
            end
            repeat ($urandom_range(3, 8)) begin
                if (sent_ticks >= stop_at) break;
                case ($urandom_range(9))
                    7: begin
                        repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(1)));
                    end
                    8: begin
                        drain();
                    end
                    9: begin
                        hold_level(1'b1, $urandom_range(1, int'(cfg_debounce) + 1));
                        hold_level(1'b0, 1);
                    end
                    default: begin
                        case ($urandom_range(3))
                            0, 1: press_len = $urandom_range(1,
                                      int'(cfg_debounce) + int'(cfg_long_press));
                            2: press_len = int'(cfg_debounce) + int'(cfg_long_press)
                                           + $urandom_range(2);
                            default: press_len = int'(cfg_debounce) + int'(cfg_long_press)
                                      + $urandom_range(31 * int'(cfg_ticks_per_s));
                        endcase
                        case ($urandom_range(2))
                            0: gap_len = $urandom_range(1, int'(cfg_double_click));
                            1: gap_len = int'(cfg_double_click) + $urandom_range(1, 3);
                            default: gap_len = $urandom_range(1, 3);
                        endcase
                        if (press_len > 250) begin
                            press_len = $urandom_range(1, 250);
                        end
                        if (gap_len > 250) begin
                            gap_len = $urandom_range(1, 250);
                        end
                        hold_level(1'b1, press_len);
                        hold_level(1'b0, gap_len);
                    end
                endcase
            end
        end
    endtask

    // Holds past the 30 s mark at three ticks per second, then lets a
    // short-press window run out.
    task automatic test_final_mark();
        configure(1'b1, 16'd1, 16'd3, 16'd5, 11'd3);
        hold_level(1'b0, 4);
        hold_level(1'b1, 100);
        hold_level(1'b0, 2);
        hold_level(1'b1, 3);
        hold_level(1'b0, 8);
    endtask

    initial begin
        tick_if.valid = 1'b0;
        tick_if.button_down = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tick_idle_pct = 37;
        rpt_stall_pct = 75;
        test_registers();
        test_basic_presses();
        test_hold_marks();
        test_enable_gating();
        test_zero_and_max_settings();
        test_random_sessions(400);

        tick_idle_pct = 75;
        rpt_stall_pct = 37;
        test_random_sessions(400);

        tick_idle_pct = 0;
        rpt_stall_pct = 0;
        test_random_sessions(400);
        test_final_mark();

        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
